FILE: design/ble_pkg.sv
// Package for the battery level estimator: sizes, scaling constants, the
// discharge curve, and the microcode program with its control word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ble_pkg;

  // Ring of the last samples averaged for each estimate: a power of two
  // from 1 to 32, so the average is a plain shift.
  localparam int SAMPLE_WINDOW = 8;

  localparam int ADC_W  = 10;
  localparam int SLOT_W = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
  localparam int AVG_SH = $clog2(SAMPLE_WINDOW);
  localparam int SUM_W  = ADC_W + SLOT_W;
  localparam int MV_W   = 13;
  localparam int PCT_W  = 7;

  // Quotient bits of the segment fraction, which runs from 0 to 5.
  localparam int SEG_Q = 3;

  // Divider sizes: dividend, divisor and quotient widths.
  localparam int DIV_NW = 16;
  localparam int DIV_DW = 9;
  localparam int DIV_QW = SEG_Q;

  // The divider ratio 2050/1000 reduces exactly to 41/20. The division by 20
  // is a multiply by 52429 and a right shift by 20, which is exact for every
  // product below 2^18.
  localparam int RATIO_NUM   = 41;
  localparam int RATIO_RECIP = 52429;
  localparam int RATIO_SH    = 20;
  localparam int PROD_W      = 16;
  localparam int SCL_W       = 12;
  localparam int REF_MV      = 600;
  localparam int ADC_BITS    = 10;
  localparam int PRESCALE    = 6;
  localparam int STEP_PCT    = 5;
  localparam int FULL_PCT    = 100;
  localparam int ACC_W       = 21;

  localparam int CURVE_POINTS = 21;
  localparam int SEG_W        = 5;

  function automatic logic [MV_W-1:0] curve_pt(input logic [SEG_W-1:0] k);
    logic [MV_W-1:0] v;
    case (k)
      5'd0:    v = 13'd3270;
      5'd1:    v = 13'd3610;
      5'd2:    v = 13'd3690;
      5'd3:    v = 13'd3710;
      5'd4:    v = 13'd3730;
      5'd5:    v = 13'd3750;
      5'd6:    v = 13'd3770;
      5'd7:    v = 13'd3790;
      5'd8:    v = 13'd3800;
      5'd9:    v = 13'd3820;
      5'd10:   v = 13'd3840;
      5'd11:   v = 13'd3850;
      5'd12:   v = 13'd3870;
      5'd13:   v = 13'd3910;
      5'd14:   v = 13'd3950;
      5'd15:   v = 13'd3980;
      5'd16:   v = 13'd4020;
      5'd17:   v = 13'd4080;
      5'd18:   v = 13'd4110;
      5'd19:   v = 13'd4150;
      5'd20:   v = 13'd4200;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_AVG      = 4'd2,
    OP_SCALE    = 4'd3,
    OP_DL_SEG   = 4'd4,
    OP_DSTEP    = 4'd5,
    OP_MUL_REF  = 4'd6,
    OP_MV       = 4'd7,
    OP_SEG      = 4'd8,
    OP_FIN      = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_JUMP     = 3'd1,
    C_WAIT_IN  = 3'd2,
    C_LOOP     = 3'd3,
    C_WAIT_OUT = 3'd4
  } cond_t;

  typedef logic [3:0] step_t;
  typedef logic [3:0] cnt_t;

  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_AVG       = 4'd1;
  localparam step_t S_SCALE     = 4'd2;
  localparam step_t S_MUL_REF   = 4'd3;
  localparam step_t S_MV        = 4'd4;
  localparam step_t S_SEG       = 4'd5;
  localparam step_t S_LOAD_SEG  = 4'd6;
  localparam step_t S_DIV_SEG   = 4'd7;
  localparam step_t S_FIN       = 4'd8;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    cnt_t  cnt;
  } uword_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    cnt_t cnt;
    logic go;
  } ctrl_t;

  // Status handed back from the datapath to the sequencer.
  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{op: OP_NOP, cond: C_JUMP, target: S_IDLE, cnt: '0};
    case (s)
      S_IDLE:     w = '{op: OP_ACCEPT,   cond: C_WAIT_IN,  target: S_AVG,      cnt: '0};
      S_AVG:      w = '{op: OP_AVG,      cond: C_NEXT,     target: S_IDLE,     cnt: '0};
      S_SCALE:    w = '{op: OP_SCALE,    cond: C_NEXT,     target: S_IDLE,     cnt: '0};
      S_MUL_REF:  w = '{op: OP_MUL_REF,  cond: C_NEXT,     target: S_IDLE,     cnt: '0};
      S_MV:       w = '{op: OP_MV,       cond: C_NEXT,     target: S_IDLE,     cnt: '0};
      S_SEG:      w = '{op: OP_SEG,      cond: C_NEXT,     target: S_IDLE,     cnt: '0};
      S_LOAD_SEG: w = '{op: OP_DL_SEG,   cond: C_NEXT,     target: S_IDLE,
                        cnt: cnt_t'(SEG_Q)};
      S_DIV_SEG:  w = '{op: OP_DSTEP,    cond: C_LOOP,     target: S_IDLE,     cnt: '0};
      S_FIN:      w = '{op: OP_FIN,      cond: C_WAIT_OUT, target: S_IDLE,     cnt: '0};
      default:    w = '{op: OP_NOP,      cond: C_JUMP,     target: S_IDLE,     cnt: '0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/ble_if.sv
// Request channels of the battery level estimator: the sample input and the
// estimate output. Depends on ble_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ble_in_if;
  logic                       valid;
  logic                       ready;
  logic [ble_pkg::ADC_W-1:0]  adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface ble_out_if;
  logic                       valid;
  logic                       ready;
  logic [ble_pkg::MV_W-1:0]   battery_mv;
  logic [ble_pkg::PCT_W-1:0]  charge_percent;

  modport source (output valid, output battery_mv, output charge_percent, input ready);
  modport sink (input valid, input battery_mv, input charge_percent, output ready);
endinterface
`default_nettype wire

FILE: design/ble_seq.sv
// Microcode sequencer: step counter, program ROM, loop counter and jumps.
// Depends on ble_pkg for the program and the control word types.
`timescale 1ns / 1ps
`default_nettype none
module ble_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ble_pkg::stat_t stat,
  output ble_pkg::ctrl_t ctrl
);
  import ble_pkg::*;

  step_t  pc_r, pc_nxt;
  cnt_t   loop_r, loop_nxt;
  uword_t uw;
  logic   go;

  assign uw = ucode(pc_r);

  always_comb begin
    go       = 1'b1;
    pc_nxt   = pc_r + step_t'(1);
    // Any step outside a loop preloads the counter for the loop after it.
    loop_nxt = uw.cnt;
    case (uw.cond)
      C_NEXT: begin
        pc_nxt = pc_r + step_t'(1);
      end
      C_JUMP: begin
        pc_nxt = uw.target;
      end
      C_WAIT_IN: begin
        go     = in_valid;
        pc_nxt = in_valid ? uw.target : pc_r;
      end
      C_LOOP: begin
        loop_nxt = loop_r - cnt_t'(1);
        pc_nxt   = (loop_r == cnt_t'(1)) ? pc_r + step_t'(1) : pc_r;
      end
      C_WAIT_OUT: begin
        go     = stat.out_free;
        pc_nxt = stat.out_free ? uw.target : pc_r;
      end
      default: begin
        pc_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= S_IDLE;
      loop_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      loop_r <= loop_nxt;
    end
  end

  // No request is taken while reset is held.
  assign in_ready = rst_n && (uw.cond == C_WAIT_IN);
  assign ctrl     = '{op: uw.op, cnt: uw.cnt, go: go};

endmodule
`default_nettype wire

FILE: design/ble_div.sv
// Restoring divider, one quotient bit per cycle, with a preset bit count.
// Depends on ble_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none
module ble_div (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  ble_pkg::cnt_t               q_bits,
  input  logic [ble_pkg::DIV_NW-1:0]  dividend,
  input  logic [ble_pkg::DIV_DW-1:0]  divisor,
  output logic [ble_pkg::DIV_QW-1:0]  quotient
);
  import ble_pkg::*;

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dsr_r, dsr_nxt;
  logic [DIV_NW-1:0] sh_r, sh_nxt;
  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [4:0]        lshamt;

  assign lshamt = 5'(DIV_NW) - 5'(q_bits);
  assign trial  = {rem_r, sh_r[DIV_NW-1]};
  assign ge     = (trial >= {1'b0, dsr_r});

  // The dividend's bits above the quotient width start as the partial
  // remainder; they are always smaller than the divisor.
  always_comb begin
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    sh_nxt  = sh_r;
    if (load) begin
      rem_nxt = DIV_DW'(dividend >> q_bits);
      dsr_nxt = divisor;
      sh_nxt  = dividend << lshamt;
    end else if (step) begin
      rem_nxt = ge ? DIV_DW'(trial - {1'b0, dsr_r}) : trial[DIV_DW-1:0];
      sh_nxt  = {sh_r[DIV_NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    sh_r  <= sh_nxt;
  end

  assign quotient = sh_r[DIV_QW-1:0];

endmodule
`default_nettype wire

FILE: design/ble_dp.sv
// Datapath: sample ring with running sum, scaling multipliers, curve segment
// search and the output register. Depends on ble_pkg and ble_div.
`timescale 1ns / 1ps
`default_nettype none
module ble_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ble_pkg::ctrl_t             ctrl,
  output ble_pkg::stat_t             stat,
  input  logic [ble_pkg::ADC_W-1:0]  adc_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ble_pkg::MV_W-1:0]   battery_mv,
  output logic [ble_pkg::PCT_W-1:0]  charge_percent
);
  import ble_pkg::*;

  logic [ADC_W-1:0]  ring_r [SAMPLE_WINDOW];
  logic [SLOT_W-1:0] slot_r;
  logic [SUM_W-1:0]  sum_r;
  logic              ov_r;

  logic [PROD_W-1:0] prod_r;
  logic [SCL_W-1:0]  scl_r;
  logic [ACC_W-1:0]  acc_r;
  logic [MV_W-1:0]   mv_r;
  logic [SEG_W-1:0]  seg_r;
  logic              above_r;
  logic [MV_W-1:0]   omv_r;
  logic [PCT_W-1:0]  opct_r;

  logic              do_accept, do_fin;
  logic              div_load, div_step;
  logic [DIV_NW-1:0] dividend;
  logic [DIV_DW-1:0] divisor;
  logic [DIV_QW-1:0] quo;
  logic [MV_W-1:0]   seg_lo, seg_hi;
  logic [SEG_W-1:0]  seg_k;
  logic              seg_found;
  logic [PCT_W-1:0]  pct;

  assign do_accept = ctrl.go && (ctrl.op == OP_ACCEPT);
  assign do_fin    = ctrl.go && (ctrl.op == OP_FIN);
  assign div_step  = ctrl.go && (ctrl.op == OP_DSTEP);
  assign div_load  = ctrl.go && (ctrl.op == OP_DL_SEG);

  assign seg_hi = curve_pt(seg_r);
  assign seg_lo = curve_pt(seg_r - SEG_W'(1));

  // Only the segment fraction goes through the divider.
  assign dividend = DIV_NW'(mv_r - seg_lo) * DIV_NW'(STEP_PCT);
  assign divisor  = DIV_DW'(seg_hi - seg_lo);

  ble_div u_div (
    .clk      (clk),
    .load     (div_load),
    .step     (div_step),
    .q_bits   (ctrl.cnt),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (quo)
  );

  // The curve rises, so the lowest point at or above the voltage wins.
  always_comb begin
    seg_k     = '0;
    seg_found = 1'b0;
    for (int i = CURVE_POINTS - 1; i >= 0; i--) begin
      if (curve_pt(SEG_W'(i)) >= mv_r) begin
        seg_k     = SEG_W'(i);
        seg_found = 1'b1;
      end
    end
  end

  always_comb begin
    if (above_r) begin
      pct = PCT_W'(FULL_PCT);
    end else if (seg_r == '0) begin
      pct = '0;
    end else begin
      pct = PCT_W'((seg_r - SEG_W'(1)) * PCT_W'(STEP_PCT)) + PCT_W'(quo[SEG_Q-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      sum_r  <= '0;
      ov_r   <= 1'b0;
      for (int i = 0; i < SAMPLE_WINDOW; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      if (do_accept) begin
        ring_r[slot_r] <= adc_sample;
        sum_r          <= sum_r - SUM_W'(ring_r[slot_r]) + SUM_W'(adc_sample);
        slot_r         <= (slot_r == SLOT_W'(SAMPLE_WINDOW - 1)) ? '0
                                                                  : slot_r + SLOT_W'(1);
      end
      if (do_fin) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go && (ctrl.op == OP_AVG)) begin
      prod_r <= PROD_W'(sum_r >> AVG_SH) * PROD_W'(RATIO_NUM);
    end
    if (ctrl.go && (ctrl.op == OP_SCALE)) begin
      scl_r <= SCL_W'((32'(prod_r) * 32'(RATIO_RECIP)) >> RATIO_SH);
    end
    if (ctrl.go && (ctrl.op == OP_MUL_REF)) begin
      acc_r <= ACC_W'(scl_r) * ACC_W'(REF_MV);
    end
    if (ctrl.go && (ctrl.op == OP_MV)) begin
      mv_r <= MV_W'((acc_r >> ADC_BITS) * ACC_W'(PRESCALE));
    end
    if (ctrl.go && (ctrl.op == OP_SEG)) begin
      seg_r   <= seg_k;
      above_r <= !seg_found;
    end
    if (do_fin) begin
      omv_r  <= mv_r;
      opct_r <= pct;
    end
  end

  assign stat           = '{out_free: (!ov_r || out_ready)};
  assign out_valid      = ov_r;
  assign battery_mv     = omv_r;
  assign charge_percent = opct_r;

endmodule
`default_nettype wire

FILE: design/battery_level_estimator_unit.sv
// Top level of the battery level estimator: sequencer plus datapath.
// Depends on ble_pkg, ble_if, ble_seq and ble_dp.
//
//   Channel   Direction  Payload                          Handshake
//   in_chan   sink       adc_sample[9:0]                  valid / ready
//   out_chan  source     battery_mv[12:0], charge_percent valid / ready
//
// A sample is taken in the idle step, and no new one until the program is
// back there. The program runs: average, ratio scaling, two millivolt
// steps, segment search, a divider load and three one-bit divider steps
// for the segment fraction, then the output step, which loads the estimate
// into the output register.
// Synchronous active-low reset clears the sample ring, running sum and
// step counter. A stalled output holds its estimate; the next sample is
// still accepted and only the final step waits for the output register.
`timescale 1ns / 1ps
`default_nettype none
module battery_level_estimator_unit (
  input  logic      clk,
  input  logic      rst_n,
  ble_in_if.sink    in_chan,
  ble_out_if.source out_chan
);
  import ble_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ble_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ble_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .adc_sample     (in_chan.adc_sample),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .battery_mv     (out_chan.battery_mv),
    .charge_percent (out_chan.charge_percent)
  );

endmodule
`default_nettype wire

FILE: dv/ble_estimate_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the battery level estimator: mirrors the sample ring, predicts
// millivolts and charge for every accepted request and checks results in order.
// Depends on ble_pkg for field widths and the averaging window.
module ble_estimate_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [ble_pkg::ADC_W-1:0] in_adc_sample,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [ble_pkg::MV_W-1:0]  out_battery_mv,
  input  logic [ble_pkg::PCT_W-1:0] out_charge_percent,
  output int                        mismatches,
  output int                        pending
);
  import ble_pkg::*;

  localparam int LIPO_POINTS = 21;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
  } estimate_t;

  estimate_t        expected_estimates[$];
  logic [ADC_W-1:0] sample_hist [SAMPLE_WINDOW];
  int unsigned      next_slot;

  function automatic int unsigned lipo_mv(input int unsigned idx);
    int unsigned v;
    case (idx)
      0:  v = 3270;
      1:  v = 3610;
      2:  v = 3690;
      3:  v = 3710;
      4:  v = 3730;
      5:  v = 3750;
      6:  v = 3770;
      7:  v = 3790;
      8:  v = 3800;
      9:  v = 3820;
      10: v = 3840;
      11: v = 3850;
      12: v = 3870;
      13: v = 3910;
      14: v = 3950;
      15: v = 3980;
      16: v = 4020;
      17: v = 4080;
      18: v = 4110;
      19: v = 4150;
      default: v = 4200;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] charge_from_mv(input int unsigned mv);
    int unsigned seg;
    int unsigned pct;
    // At or below the first point the charge reads empty.
    if (mv <= lipo_mv(0)) return '0;
    seg = 1;
    while (seg < LIPO_POINTS && lipo_mv(seg) < mv) seg++;
    if (seg == LIPO_POINTS) return PCT_W'(100);
    pct = 5 * (seg - 1) + (5 * (mv - lipo_mv(seg - 1))) / (lipo_mv(seg) - lipo_mv(seg - 1));
    return pct[PCT_W-1:0];
  endfunction

  function automatic estimate_t predict_estimate(input logic [ADC_W-1:0] sample);
    int unsigned total;
    int unsigned avg;
    int unsigned scaled;
    int unsigned mv;
    estimate_t   est;
    sample_hist[next_slot] = sample;
    next_slot = (next_slot + 1) % SAMPLE_WINDOW;
    total = 0;
    for (int i = 0; i < SAMPLE_WINDOW; i++) total += sample_hist[i];
    avg = total / SAMPLE_WINDOW;
    scaled = (avg * 2050) / 1000;
    mv = ((scaled * 600) / 1024) * 6;
    est.mv  = mv[MV_W-1:0];
    est.pct = charge_from_mv(mv);
    return est;
  endfunction

  always @(posedge clk) begin
    estimate_t want;
    if (!rst_n) begin
      for (int i = 0; i < SAMPLE_WINDOW; i++) sample_hist[i] = '0;
      next_slot = 0;
      expected_estimates.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: estimate with no request outstanding: mv=%0d pct=%0d",
                     $realtime, out_battery_mv, out_charge_percent);
          mismatches++;
        end else begin
          want = expected_estimates.pop_front();
          if (want.mv !== out_battery_mv || want.pct !== out_charge_percent) begin
            if (mismatches < 10)
              $display("%0t: estimate mismatch: expected mv=%0d pct=%0d, got mv=%0d pct=%0d",
                       $realtime, want.mv, want.pct, out_battery_mv, out_charge_percent);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_estimates.push_back(predict_estimate(in_adc_sample));
    end
    pending <= expected_estimates.size();
  end

endmodule

FILE: dv/tb_battery_level_estimator_unit.sv
`timescale 1ns / 1ps
// Testbench top for battery_level_estimator_unit: drives sample requests and
// output back-pressure, and gives the verdict. Depends on ble_pkg, ble_if,
// the estimator RTL and ble_estimate_checker.
module tb_battery_level_estimator_unit;
  import ble_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AFTER   = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BLOCKS = 17;
  localparam int BLOCK_ITEMS  = 50;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   mismatches;
  int   pending;
  bit   tx_steady;
  bit   rx_steady;

  ble_in_if  in_chan ();
  ble_out_if out_chan ();

  battery_level_estimator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ble_estimate_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_chan.valid),
    .in_ready           (in_chan.ready),
    .in_adc_sample      (in_chan.adc_sample),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_battery_mv     (out_chan.battery_mv),
    .out_charge_percent (out_chan.charge_percent),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** battery_level_estimator_unit: FAILED **");
      $finish;
    end
  end

  // Offers one sample after an idle gap and returns at the falling edge after
  // the request is taken, so a zero gap keeps valid high across requests.
  task automatic send_sample(input logic [ADC_W-1:0] sample, input int gap);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      = 1'b1;
    in_chan.adc_sample = sample;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  function automatic int tx_gap();
    return tx_steady ? 0 : $urandom_range(0, 5);
  endfunction

  // Receiver: random stalls per result, plus one long hold-off once a fixed
  // number of results has been taken.
  initial begin
    int stall;
    int taken;
    out_chan.ready = 1'b0;
    taken = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken == HOLD_AFTER) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = rx_steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready = 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int               level;
    int               draw;
    logic [ADC_W-1:0] sample;

    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.adc_sample = '0;
    tx_steady          = 1'b0;
    rx_steady          = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Warm-up from an all-zero ring, then settle just around the bottom of the
    // curve, then drive well above its top.
    send_sample('0, tx_gap());
    for (int i = 0; i < 8; i++) send_sample(ADC_W'(455), tx_gap());
    send_sample(ADC_W'(454), tx_gap());
    for (int i = 0; i < 8; i++) send_sample('1, tx_gap());
    send_sample(ADC_W'(10'h2AA), tx_gap());
    send_sample(ADC_W'(10'h155), tx_gap());
    send_sample('0, tx_gap());
    send_sample('1, tx_gap());

    // Mostly slow drifts across the curve region, with full-range noise.
    level = $urandom_range(440, 600);
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (blk == 9) begin
        in_chan.valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if ($urandom_range(0, 15) == 0) level = $urandom_range(440, 600);
        draw = $urandom_range(0, 9);
        if (draw < 7)
          sample = ADC_W'(level + $urandom_range(0, 8) - 4);
        else
          sample = ADC_W'($urandom_range(0, 1023));
        send_sample(sample, tx_gap());
      end
    end
    in_chan.valid = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("** battery_level_estimator_unit: PASSED **");
    else
      $display("** battery_level_estimator_unit: FAILED **");
    $finish;
  end

endmodule
